// File: rtl/core/bwrq_pkg.sv
// bwrq_pkg: shared types, constants and opcodes of the bitmap rank query unit
// no dependencies; imported by every module of the block
`default_nettype none

package bwrq_pkg;

  // bitmap geometry
  localparam int unsigned WordCount = 4;
  localparam int unsigned WordW     = 64;
  localparam int unsigned TotalBits = WordCount * WordW;
  localparam int unsigned WordSelW  = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int unsigned PcntW     = $clog2(WordW + 1);
  localparam int unsigned CntW      = $clog2(TotalBits + 1);
  localparam int unsigned LimW      = (CntW > 9) ? CntW : 9;

  // beat field widths
  localparam int unsigned OpW    = 4;
  localparam int unsigned BitIdxW = 8;
  localparam int unsigned LimInW = 9;
  localparam int unsigned WIdxW  = 2;
  localparam int unsigned RankW  = 9;

  localparam logic [WordW-1:0] AllOnes = {WordW{1'b1}};

  typedef enum logic [OpW-1:0] {
    OpSet       = 4'd0,
    OpClear     = 4'd1,
    OpTest      = 4'd2,
    OpSetAll    = 4'd3,
    OpClearAll  = 4'd4,
    OpFlipAll   = 4'd5,
    OpRank      = 4'd6,
    OpOrWord    = 4'd7,
    OpAndWord   = 4'd8,
    OpWriteWord = 4'd9
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]     opcode;
    logic [BitIdxW-1:0] bit_index;
    logic [LimInW-1:0]  rank_limit;
    logic [WIdxW-1:0]   word_index;
    logic [WordW-1:0]   word_value;
  } item_t;

  typedef struct packed {
    logic                            bit_value;
    logic [WordW-1:0]                word_out;
    logic [WordCount-1:0][PcntW-1:0] part_cnt;
  } exec_res_t;

endpackage

`default_nettype wire

// File: rtl/core/bwrq_popcnt.sv
// bwrq_popcnt: population count of one 64-bit word, tree of pairwise adds
// depends on bwrq_pkg
`default_nettype none

module bwrq_popcnt (
  input  logic [bwrq_pkg::WordW-1:0] word_i,
  output logic [bwrq_pkg::PcntW-1:0] count_o
);
  import bwrq_pkg::*;

  logic [WordW-1:0] s1, s2, s3, s4, s5, s6;

  always_comb begin
    s1 = (word_i & 64'h5555555555555555) + ((word_i >> 1) & 64'h5555555555555555);
    s2 = (s1 & 64'h3333333333333333) + ((s1 >> 2) & 64'h3333333333333333);
    s3 = (s2 & 64'h0f0f0f0f0f0f0f0f) + ((s2 >> 4) & 64'h0f0f0f0f0f0f0f0f);
    s4 = (s3 & 64'h00ff00ff00ff00ff) + ((s3 >> 8) & 64'h00ff00ff00ff00ff);
    s5 = (s4 & 64'h0000ffff0000ffff) + ((s4 >> 16) & 64'h0000ffff0000ffff);
    s6 = (s5 & 64'h00000000ffffffff) + ((s5 >> 32) & 64'h00000000ffffffff);
  end

  assign count_o = s6[PcntW-1:0];

endmodule

`default_nettype wire

// File: rtl/core/bwrq_exec.sv
// bwrq_exec: bitmap register, its update logic and masked per-word counts
// depends on bwrq_pkg and bwrq_popcnt
`default_nettype none

module bwrq_exec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  bwrq_pkg::item_t     item_i,
  output bwrq_pkg::exec_res_t res_o
);
  import bwrq_pkg::*;

  logic [WordW-1:0] words_q [WordCount];
  logic [WordW-1:0] words_d [WordCount];

  logic [WIdxW-1:0]    bword;
  logic [WordSelW-1:0] bsel, wsel, rsel;
  logic                bok, wok, rok;
  logic [WordW-1:0]    bmask;
  op_e                 op;
  logic [LimW-1:0]     lim_ext, lim_sat;

  logic                            bit_value;
  logic [WordW-1:0]                word_out;
  logic [WordCount-1:0][PcntW-1:0] part_cnt;

  assign op    = op_e'(item_i.opcode);
  assign bword = item_i.bit_index[BitIdxW-1:6];
  assign bsel  = WordSelW'(bword);
  assign wsel  = WordSelW'(item_i.word_index);
  assign bok   = 32'(bword) < WordCount;
  assign wok   = 32'(item_i.word_index) < WordCount;
  assign bmask = WordW'(1) << item_i.bit_index[5:0];

  always_comb begin
    for (int w = 0; w < WordCount; w++) words_d[w] = words_q[w];
    bit_value = 1'b0;
    case (op)
      OpSet:       if (bok) words_d[bsel] = words_q[bsel] | bmask;
      OpClear:     if (bok) words_d[bsel] = words_q[bsel] & ~bmask;
      OpTest:      if (bok) bit_value = |(words_q[bsel] & bmask);
      OpSetAll:    for (int w = 0; w < WordCount; w++) words_d[w] = AllOnes;
      OpClearAll:  for (int w = 0; w < WordCount; w++) words_d[w] = '0;
      OpFlipAll:   for (int w = 0; w < WordCount; w++) words_d[w] = ~words_q[w];
      OpOrWord:    if (wok) words_d[wsel] = words_q[wsel] | item_i.word_value;
      OpAndWord:   if (wok) words_d[wsel] = words_q[wsel] & item_i.word_value;
      OpWriteWord: if (wok) words_d[wsel] = item_i.word_value;
      default: ;
    endcase
  end

  // set, clear and test report the word holding the bit, the rest word_index
  always_comb begin
    if (item_i.opcode <= OpTest) begin
      rsel = bsel;
      rok  = bok;
    end else begin
      rsel = wsel;
      rok  = wok;
    end
  end
  assign word_out = rok ? words_d[rsel] : '0;

  // rank limit saturates at the bitmap size
  assign lim_ext = LimW'(item_i.rank_limit);
  assign lim_sat = (lim_ext > LimW'(TotalBits)) ? LimW'(TotalBits) : lim_ext;

  for (genvar w = 0; w < WordCount; w++) begin : g_word
    localparam logic [LimW-1:0] Lo = LimW'(w * WordW);
    localparam logic [LimW-1:0] Hi = LimW'((w + 1) * WordW);
    logic [WordW-1:0] cmask;

    always_comb begin
      if (op != OpRank)          cmask = '0;
      else if (lim_sat >= Hi)    cmask = AllOnes;
      else if (lim_sat > Lo)     cmask = (WordW'(1) << lim_sat[5:0]) - WordW'(1);
      else                       cmask = '0;
    end

    bwrq_popcnt u_popcnt (
      .word_i (words_q[w] & cmask),
      .count_o(part_cnt[w])
    );
  end

  assign res_o = {bit_value, word_out, part_cnt};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WordCount; w++) words_q[w] <= '0;
    end else if (en_i) begin
      for (int w = 0; w < WordCount; w++) words_q[w] <= words_d[w];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bitmap_with_rank_query_unit.sv
// bitmap_with_rank_query_unit: top level of the 256-bit bitmap with rank query
// depends on bwrq_pkg and bwrq_exec
`default_nettype none

// Bitmap of four 64-bit words, all zero after reset, with single-bit,
// whole-map and word operations plus a rank query (set bits strictly below
// rank_limit, limit saturating at 256). Every input beat yields exactly one
// output beat, in order. Throughput is one beat per clock cycle while the
// output is not stalled; a beat passes through three registers: the input
// register, the execute stage where the bitmap register updates and the
// per-word masked popcounts are registered, and the output register which
// takes the sum of the four partial counts. Updating the bitmap as each beat
// leaves the execute stage is what lets each beat see the result of the one
// before it. When the output beat is stalled the whole pipeline holds, so
// in_stall_o follows out_stall_i while an output beat is waiting.
module bitmap_with_rank_query_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bwrq_pkg::OpW-1:0]     opcode_i,
  input  logic [bwrq_pkg::BitIdxW-1:0] bit_index_i,
  input  logic [bwrq_pkg::LimInW-1:0]  rank_limit_i,
  input  logic [bwrq_pkg::WIdxW-1:0]   word_index_i,
  input  logic [bwrq_pkg::WordW-1:0]   word_value_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      bit_value_o,
  output logic [bwrq_pkg::RankW-1:0]  rank_count_o,
  output logic [bwrq_pkg::WordW-1:0]  word_out_o
);
  import bwrq_pkg::*;

  // global pipeline enable: move unless a finished beat is held
  logic advance;

  logic      s1_valid_q, s2_valid_q, out_valid_q;
  item_t     item_q;
  exec_res_t res, res_q;
  logic [LimW-1:0] rank_sum;

  logic             bit_value_q;
  logic [RankW-1:0] rank_count_q;
  logic [WordW-1:0] word_out_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      item_q.opcode     <= opcode_i;
      item_q.bit_index  <= bit_index_i;
      item_q.rank_limit <= rank_limit_i;
      item_q.word_index <= word_index_i;
      item_q.word_value <= word_value_i;
    end
  end

  // execute: bitmap update commits only for a real beat moving on
  bwrq_exec u_exec (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (s1_valid_q && advance),
    .item_i(item_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) res_q <= res;
  end

  // sum of the per-word partial counts, zero for non-rank beats
  always_comb begin
    rank_sum = '0;
    for (int w = 0; w < WordCount; w++) rank_sum = rank_sum + LimW'(res_q.part_cnt[w]);
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (advance && s2_valid_q) begin
      bit_value_q  <= res_q.bit_value;
      rank_count_q <= rank_sum[RankW-1:0];
      word_out_q   <= res_q.word_out;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bit_value_o  = bit_value_q;
  assign rank_count_o = rank_count_q;
  assign word_out_o   = word_out_q;

endmodule

`default_nettype wire

// File: rtl/core/bwrq_checker.sv
// bwrq_checker: port-level assertions for the bitmap rank query unit, with bind
// depends on bwrq_pkg and bitmap_with_rank_query_unit
`default_nettype none

module bwrq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         bit_value_o,
  input logic [bwrq_pkg::RankW-1:0]   rank_count_o,
  input logic [bwrq_pkg::WordW-1:0]   word_out_o
);
  import bwrq_pkg::*;

  // a stalled output beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // a stalled output payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(word_out_o) && $stable(rank_count_o)
                                   && $stable(bit_value_o))
    else $error("output payload changed while stalled");

  // with no output beat waiting the input side never stalls
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // only a test beat carries a bit, only a rank beat carries a count
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bit_value_o |-> rank_count_o == '0)
    else $error("bit value and rank count both nonzero");

  // a rank count never exceeds the bitmap size
  a_rank_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(rank_count_o) <= TotalBits)
    else $error("rank count above bitmap size");

endmodule

bind bitmap_with_rank_query_unit bwrq_checker u_bwrq_checker (.*);

`default_nettype wire

// File: verif/testbench.sv
// testbench: self-checking bench for bitmap_with_rank_query_unit
// depends on bwrq_pkg and the unit; a shadow bitmap predicts the output beats of unpinned rows
`timescale 1ns / 1ps

module testbench;
  import bwrq_pkg::*;

  // opcodes the unit leaves unused; the map holds and the addressed word comes back
  localparam logic [OpW-1:0] FirstUnusedOp = 4'd10;
  localparam logic [OpW-1:0] LastUnusedOp  = 4'd15;

  // number of random beats, split over the three idle/stall mixes
  localparam int unsigned RandomBeats = 1250;
  localparam int unsigned PhaseCount  = 3;

  // beats still in the pipe after the last accept: input reg, execute, output reg
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic             bit_value;
    logic [RankW-1:0] rank_count;
    logic [WordW-1:0] word_out;
  } beat_result_t;

  // one stimulus row; pinned rows carry a result read straight off the spec
  typedef struct {
    item_t        beat;
    bit           pinned;
    beat_result_t want;
  } row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [OpW-1:0]      opcode_i     = '0;
  logic [BitIdxW-1:0]  bit_index_i  = '0;
  logic [LimInW-1:0]   rank_limit_i = '0;
  logic [WIdxW-1:0]    word_index_i = '0;
  logic [WordW-1:0]    word_value_i = '0;

  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic                bit_value_o;
  logic [RankW-1:0]    rank_count_o;
  logic [WordW-1:0]    word_out_o;

  // shadow copy of the bitmap, word 0 in the low bits so bit_index maps straight in
  logic [WordCount-1:0][WordW-1:0] shadow_map = '0;

  beat_result_t pending_results [$];
  row_t         directed_rows [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned beats_sent     = 0;
  int unsigned beats_checked  = 0;
  int unsigned mismatch_count = 0;

  bitmap_with_rank_query_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .bit_index_i  (bit_index_i),
    .rank_limit_i (rank_limit_i),
    .word_index_i (word_index_i),
    .word_value_i (word_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bit_value_o  (bit_value_o),
    .rank_count_o (rank_count_o),
    .word_out_o   (word_out_o)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop: a run that hangs ends as a failure
  initial begin
    #2000000;
    $display("bitmap_with_rank_query_unit test failed");
    $finish;
  end

  // set bits strictly below limit, limit saturating at the map size
  function automatic logic [RankW-1:0] ones_below(logic [LimInW-1:0] limit);
    logic [TotalBits-1:0] keep;
    int unsigned          lim;
    lim  = (limit > TotalBits) ? TotalBits : limit;
    keep = (lim == TotalBits) ? '1 : ((TotalBits'(1) << lim) - 1'b1);
    return RankW'($countones(shadow_map & keep));
  endfunction

  // apply one beat to the shadow map and return the beat it should produce
  function automatic beat_result_t apply_to_shadow(item_t b);
    beat_result_t r;
    logic [1:0]   bit_word;
    logic [5:0]   bit_pos;
    r        = '0;
    bit_word = b.bit_index[7:6];
    bit_pos  = b.bit_index[5:0];
    case (b.opcode)
      OpSet:       shadow_map[bit_word][bit_pos] = 1'b1;
      OpClear:     shadow_map[bit_word][bit_pos] = 1'b0;
      OpTest:      r.bit_value = shadow_map[bit_word][bit_pos];
      OpSetAll:    shadow_map = '1;
      OpClearAll:  shadow_map = '0;
      OpFlipAll:   shadow_map = ~shadow_map;
      OpRank:      r.rank_count = ones_below(b.rank_limit);
      OpOrWord:    shadow_map[b.word_index] = shadow_map[b.word_index] | b.word_value;
      OpAndWord:   shadow_map[b.word_index] = shadow_map[b.word_index] & b.word_value;
      OpWriteWord: shadow_map[b.word_index] = b.word_value;
      default: ;
    endcase
    // single-bit ops report the word holding the bit, the rest the indexed word
    if (b.opcode <= OpTest) begin
      r.word_out = shadow_map[bit_word];
    end else begin
      r.word_out = shadow_map[b.word_index];
    end
    return r;
  endfunction

  function automatic item_t make_beat(logic [OpW-1:0] op, logic [BitIdxW-1:0] bidx,
                                      logic [LimInW-1:0] lim, logic [WIdxW-1:0] widx,
                                      logic [WordW-1:0] wval);
    item_t b;
    b.opcode     = op;
    b.bit_index  = bidx;
    b.rank_limit = lim;
    b.word_index = widx;
    b.word_value = wval;
    return b;
  endfunction

  // row whose result is typed in
  function automatic row_t typed_row(logic [OpW-1:0] op, logic [BitIdxW-1:0] bidx,
                                     logic [LimInW-1:0] lim, logic [WIdxW-1:0] widx,
                                     logic [WordW-1:0] wval, logic bitv,
                                     logic [RankW-1:0] rank, logic [WordW-1:0] word);
    row_t r;
    r.beat   = make_beat(op, bidx, lim, widx, wval);
    r.pinned = 1'b1;
    r.want   = '{bit_value: bitv, rank_count: rank, word_out: word};
    return r;
  endfunction

  // row checked against the shadow map
  function automatic row_t model_row(logic [OpW-1:0] op, logic [BitIdxW-1:0] bidx,
                                     logic [LimInW-1:0] lim, logic [WIdxW-1:0] widx,
                                     logic [WordW-1:0] wval);
    row_t r;
    r.beat   = make_beat(op, bidx, lim, widx, wval);
    r.pinned = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  // random beat: mostly bit, rank and word ops, few whole-map wipes, rare unused codes
  function automatic row_t random_row();
    item_t       b;
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (pick < 14)      b.opcode = OpSet;
    else if (pick < 26) b.opcode = OpClear;
    else if (pick < 40) b.opcode = OpTest;
    else if (pick < 56) b.opcode = OpRank;
    else if (pick < 66) b.opcode = OpOrWord;
    else if (pick < 76) b.opcode = OpAndWord;
    else if (pick < 86) b.opcode = OpWriteWord;
    else if (pick < 89) b.opcode = OpSetAll;
    else if (pick < 92) b.opcode = OpClearAll;
    else if (pick < 97) b.opcode = OpFlipAll;
    else                b.opcode = OpW'($urandom_range(FirstUnusedOp, LastUnusedOp));
    b.bit_index  = BitIdxW'($urandom_range(0, 255));
    b.word_index = WIdxW'($urandom_range(0, WordCount - 1));
    // limits: word boundaries and one past, beyond the map, or anywhere
    pick = $urandom_range(0, 99);
    if (pick < 15)      b.rank_limit = LimInW'($urandom_range(0, 4) * 64 + $urandom_range(0, 1));
    else if (pick < 25) b.rank_limit = LimInW'($urandom_range(TotalBits + 1, 511));
    else                b.rank_limit = LimInW'($urandom_range(0, TotalBits));
    // operands: zero, all ones, one bit set or cleared, or dense random
    k    = $urandom_range(0, WordW - 1);
    pick = $urandom_range(0, 9);
    case (pick)
      0:       b.word_value = '0;
      1:       b.word_value = AllOnes;
      2:       b.word_value = WordW'(1) << k;
      3:       b.word_value = ~(WordW'(1) << k);
      default: b.word_value = {$urandom, $urandom};
    endcase
    return model_row(b.opcode, b.bit_index, b.rank_limit, b.word_index, b.word_value);
  endfunction

  task automatic report_mismatch(string what, logic [WordW-1:0] want, logic [WordW-1:0] got);
    mismatch_count++;
    $display("mismatch on %s at output beat %0d: expected %h, got %h",
             what, beats_checked, want, got);
  endtask

  // drive one beat, hold it until accepted, then queue what it should produce
  task automatic send_row(input row_t r);
    beat_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= r.beat.opcode;
    bit_index_i  <= r.beat.bit_index;
    rank_limit_i <= r.beat.rank_limit;
    word_index_i <= r.beat.word_index;
    word_value_i <= r.beat.word_value;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    // accepted at this edge; the shadow map moves in step with the unit
    predicted = apply_to_shadow(r.beat);
    pending_results.push_back(r.pinned ? r.want : predicted);
    beats_sent++;
  endtask

  // receiver back-pressure, mix set by the stimulus phase
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // compare every accepted output beat with the oldest prediction
  always @(posedge clk_i) begin : check_results
    beat_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected output beat", '0, word_out_o);
      end else begin
        want = pending_results.pop_front();
        if (bit_value_o !== want.bit_value) begin
          report_mismatch("bit_value", WordW'(want.bit_value), WordW'(bit_value_o));
        end
        if (rank_count_o !== want.rank_count) begin
          report_mismatch("rank_count", WordW'(want.rank_count), WordW'(rank_count_o));
        end
        if (word_out_o !== want.word_out) begin
          report_mismatch("word_out", want.word_out, word_out_o);
        end
      end
      beats_checked++;
    end
  end

  initial begin
    // directed table: after reset, extremes of every field, every op, unused codes
    directed_rows = '{
      // empty map after reset
      typed_row(OpTest,      8'd0,   9'd0,   2'd0, '0, 1'b0, 9'd0, '0),
      typed_row(OpRank,      8'd0,   9'd256, 2'd1, '0, 1'b0, 9'd0, '0),
      // full map: rank at the top, beyond the map and at zero
      typed_row(OpSetAll,    8'd0,   9'd0,   2'd3, '0, 1'b0, 9'd0, AllOnes),
      typed_row(OpRank,      8'd0,   9'd256, 2'd0, '0, 1'b0, 9'd256, AllOnes),
      typed_row(OpRank,      8'd0,   9'd511, 2'd2, '0, 1'b0, 9'd256, AllOnes),
      typed_row(OpRank,      8'd0,   9'd0,   2'd1, '0, 1'b0, 9'd0, AllOnes),
      // clear and test touch only the addressed bit
      typed_row(OpClear,     8'd255, 9'd0,   2'd0, '0, 1'b0, 9'd0, 64'h7fff_ffff_ffff_ffff),
      typed_row(OpTest,      8'd255, 9'd0,   2'd0, '0, 1'b0, 9'd0, 64'h7fff_ffff_ffff_ffff),
      typed_row(OpTest,      8'd254, 9'd0,   2'd0, '0, 1'b1, 9'd0, 64'h7fff_ffff_ffff_ffff),
      typed_row(OpRank,      8'd0,   9'd255, 2'd3, '0, 1'b0, 9'd255, 64'h7fff_ffff_ffff_ffff),
      typed_row(OpRank,      8'd0,   9'd256, 2'd0, '0, 1'b0, 9'd255, AllOnes),
      // flip leaves only the top bit
      typed_row(OpFlipAll,   8'd0,   9'd0,   2'd3, '0, 1'b0, 9'd0, 64'h8000_0000_0000_0000),
      typed_row(OpRank,      8'd0,   9'd256, 2'd3, '0, 1'b0, 9'd1, 64'h8000_0000_0000_0000),
      typed_row(OpClearAll,  8'd0,   9'd0,   2'd0, '0, 1'b0, 9'd0, '0),
      typed_row(OpSet,       8'd0,   9'd0,   2'd2, '0, 1'b0, 9'd0, 64'h1),
      typed_row(OpSet,       8'd63,  9'd0,   2'd2, '0, 1'b0, 9'd0, 64'h8000_0000_0000_0001),
      // word ops
      typed_row(OpWriteWord, 8'd0,   9'd0,   2'd2, AllOnes, 1'b0, 9'd0, AllOnes),
      typed_row(OpAndWord,   8'd0,   9'd0,   2'd2, 64'h5555_5555_5555_5555,
                1'b0, 9'd0, 64'h5555_5555_5555_5555),
      typed_row(OpOrWord,    8'd0,   9'd0,   2'd1, 64'h3333_3333_3333_3333,
                1'b0, 9'd0, 64'h3333_3333_3333_3333),
      // partial-word ranks and a test in the third word
      model_row(OpRank,      8'd0,   9'd130, 2'd1, '0),
      model_row(OpRank,      8'd0,   9'd64,  2'd0, '0),
      model_row(OpTest,      8'd128, 9'd0,   2'd3, '0),
      // unused codes hold the map
      model_row(FirstUnusedOp, 8'd17,  9'd77,  2'd2, AllOnes),
      model_row(LastUnusedOp,  8'd200, 9'd300, 2'd1, 64'h0f0f_0f0f_0f0f_0f0f),
      model_row(OpClear,     8'd0,   9'd0,   2'd0, '0)
    };

    // hold reset, then release it at an edge
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, phase 0 mix: sender idles 31 in 100, receiver stalls 59 in 100
    send_idle_pct  = 31;
    recv_stall_pct = 59;
    foreach (directed_rows[i]) begin
      send_row(directed_rows[i]);
    end

    for (int phase = 0; phase < PhaseCount; phase++) begin
      // phase 1 swaps the mix, phase 2 runs back to back
      case (phase)
        0: begin
          send_idle_pct  = 31;
          recv_stall_pct = 59;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 31;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < RandomBeats / PhaseCount; n++) begin
        send_row(random_row());
      end
    end

    // drain: wait for every predicted beat, then DrainCycles more for strays
    in_valid_i     <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d input beats (%0d directed), %0d output beats checked",
             beats_sent, directed_rows.size(), beats_checked);
    $display("all ten ops plus unused codes, under three idle/stall mixes; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("bitmap_with_rank_query_unit test passed");
    end else begin
      $display("bitmap_with_rank_query_unit test failed");
    end
    $finish;
  end

endmodule
